// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the crossing time capture block.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// ante holds at an edge -> cons holds at the same edge
`define ASSERT_IMPLIES(name, clk_i, rstn_i, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// ante holds at an edge -> cons holds at the next edge
`define ASSERT_NEXT(name, clk_i, rstn_i, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(name, clk_i, rstn_i, ante, cons)
`define ASSERT_NEXT(name, clk_i, rstn_i, ante, cons)

`endif

`endif

// ===== hdl/fmct_pkg.sv =====
// Package for the four microphone crossing time capture block.
// Item, result, config and status types plus fixed constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fmct_pkg;

	localparam int NCH        = 4;
	localparam int SMP_W      = 12;
	localparam int TIME_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HYST      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GUARANTEE = 3'd4;

	// reset values
	localparam logic [SMP_W-1:0]  TRIG_RESET   = 12'd2048;
	localparam logic [10:0]       HYST_RESET   = 11'd100;
	localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd1000;
	localparam logic [TIME_W-1:0] GUAR_RESET   = 32'd5000;
	localparam logic [SMP_W-1:0]  RESET_LEVEL  = 12'd2048;
	localparam logic [TIME_W-1:0] NO_TIME      = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [SMP_W-1:0]  sample_ch0;
		logic [SMP_W-1:0]  sample_ch1;
		logic [SMP_W-1:0]  sample_ch2;
		logic [SMP_W-1:0]  sample_ch3;
		logic [TIME_W-1:0] time_now;
	} in_item_t;

	typedef struct packed {
		logic              ready_res;
		logic              use_rising;
		logic [TIME_W-1:0] time_ch0;
		logic [TIME_W-1:0] time_ch1;
		logic [TIME_W-1:0] time_ch2;
		logic [TIME_W-1:0] time_ch3;
	} out_item_t;

	// classified item: crossing flags per channel plus its timestamp
	typedef struct packed {
		logic [NCH-1:0]    up;
		logic [NCH-1:0]    dn;
		logic [TIME_W-1:0] time_now;
	} class_item_t;

	typedef struct packed {
		logic              continuous_mode;
		logic [SMP_W-1:0]  trigger_level;
		logic [10:0]       hysteresis;
		logic [TIME_W-1:0] window_ticks;
		logic [TIME_W-1:0] guarantee_ticks;
	} cfg_t;

	typedef struct packed {
		logic           gate_open;
		logic           gate_rising;
		logic [NCH-1:0] rise_valid;
		logic [NCH-1:0] fall_valid;
	} gate_status_t;

endpackage

`default_nettype wire

// ===== hdl/fmct_fifo.sv =====
// Small synchronous queue used between front and back and at the result side.
// Depends on nothing; payload width is a parameter.
`timescale 1ns / 1ps
`default_nettype none

module fmct_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (do_rd) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/fmct_front.sv =====
// Front end: detects threshold crossings with hysteresis on all four channels.
// Depends on fmct_pkg; keeps the previous sample of each channel.
`timescale 1ns / 1ps
`default_nettype none

module fmct_front
	import fmct_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire in_item_t    item,
	input  wire logic        accept,
	input  wire cfg_t        cfg,
	output class_item_t      cls
);

	localparam logic [SMP_W-1:0] SMASK =
		(SAMPLE_BITS >= SMP_W) ? {SMP_W{1'b1}} : SMP_W'((1 << SAMPLE_BITS) - 1);

	logic [SMP_W-1:0]  prev_q [NCH];
	logic [SMP_W-1:0]  cur    [NCH];
	logic signed [13:0] up_t;
	logic signed [13:0] down_t;
	logic signed [13:0] cur_s;
	logic signed [13:0] last_s;

	// thresholds as exact signed values; the lower one may go negative
	assign up_t   = $signed({2'b00, cfg.trigger_level}) + $signed({3'b000, cfg.hysteresis});
	assign down_t = $signed({2'b00, cfg.trigger_level}) - $signed({3'b000, cfg.hysteresis});

	// crossing flags per channel
	always_comb begin
		cur[0] = item.sample_ch0 & SMASK;
		cur[1] = item.sample_ch1 & SMASK;
		cur[2] = item.sample_ch2 & SMASK;
		cur[3] = item.sample_ch3 & SMASK;
		cls.time_now = item.time_now;
		cls.up = '0;
		cls.dn = '0;
		cur_s  = '0;
		last_s = '0;
		for (int i = 0; i < NCH; i++) begin
			cur_s  = $signed({2'b00, cur[i]});
			last_s = $signed({2'b00, prev_q[i]});
			cls.up[i] = (last_s < down_t) && (cur_s >= up_t);
			cls.dn[i] = (last_s > up_t) && (cur_s <= down_t);
		end
	end

	// previous samples advance on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				prev_q[i] <= RESET_LEVEL & SMASK;
			end
		end else if (accept) begin
			for (int i = 0; i < NCH; i++) begin
				prev_q[i] <= cur[i];
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/fmct_back.sv =====
// Back end: gate, window, record and direction choice; builds one result per item.
// Depends on fmct_pkg; takes classified items from the middle queue.
`timescale 1ns / 1ps
`default_nettype none

module fmct_back
	import fmct_pkg::*;
#(
	parameter int MIN_HITS = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        mode_wr,
	input  wire class_item_t cls,
	input  wire logic        cls_valid,
	input  wire logic        res_full,
	output logic             take,
	output out_item_t        res,
	output gate_status_t     status
);

	localparam logic [2:0] MIN_W = 3'(MIN_HITS);

	logic              gate_open_q;
	logic              gate_rising_q;
	logic [TIME_W-1:0] gate_start_q;
	logic              chosen_valid_q;
	logic              chosen_rising_q;
	logic [TIME_W-1:0] rise_time_q [NCH];
	logic [TIME_W-1:0] fall_time_q [NCH];
	logic [NCH-1:0]    rise_valid_q;
	logic [NCH-1:0]    fall_valid_q;

	logic              found;
	logic              first_up;
	logic              opening;
	logic              gd;
	logic [TIME_W-1:0] start;
	logic [TIME_W-1:0] dt;
	logic              inwin;
	logic [NCH-1:0]    rec_up;
	logic [NCH-1:0]    rec_dn;
	logic [NCH-1:0]    rv1;
	logic [NCH-1:0]    fv1;
	logic [TIME_W-1:0] rt1 [NCH];
	logic [TIME_W-1:0] ft1 [NCH];
	logic [2:0]        rc;
	logic [2:0]        fc;
	logic              up_ok;
	logic              dn_ok;
	logic              sel;
	logic              gate_open_d;
	logic              gate_rising_d;
	logic              chosen_valid_d;
	logic              chosen_rising_d;
	logic              use_up;
	logic              ready;
	logic [TIME_W-1:0] tout [NCH];

	// largest minus smallest recorded time, plain unsigned values
	function automatic logic [TIME_W-1:0] spread(input logic [NCH-1:0] v,
			input logic [TIME_W-1:0] t [NCH]);
		logic              any;
		logic [TIME_W-1:0] lo;
		logic [TIME_W-1:0] hi;
		any = 1'b0;
		lo  = '0;
		hi  = '0;
		for (int i = 0; i < NCH; i++) begin
			if (v[i]) begin
				if (!any || t[i] < lo) lo = t[i];
				if (!any || t[i] > hi) hi = t[i];
				any = 1'b1;
			end
		end
		return any ? hi - lo : NO_TIME;
	endfunction

	assign take = cls_valid && !res_full;

	// gate opening by the lowest crossing channel, then recording
	always_comb begin
		found    = 1'b0;
		first_up = 1'b0;
		for (int i = 0; i < NCH; i++) begin
			if (!found && (cls.up[i] || cls.dn[i])) begin
				first_up = cls.up[i];
				found    = 1'b1;
			end
		end
		opening = !gate_open_q && found;
		gd      = opening ? first_up : gate_rising_q;
		start   = opening ? cls.time_now : gate_start_q;
		dt      = cls.time_now - start;
		inwin   = dt < cfg.window_ticks;
		rec_up  = cls.up & {NCH{gd && inwin}};
		rec_dn  = cls.dn & {NCH{!gd && inwin}};
		rv1     = (opening ? '0 : rise_valid_q) | rec_up;
		fv1     = (opening ? '0 : fall_valid_q) | rec_dn;
		for (int i = 0; i < NCH; i++) begin
			rt1[i] = rec_up[i] ? cls.time_now : rise_time_q[i];
			ft1[i] = rec_dn[i] ? cls.time_now : fall_time_q[i];
		end
	end

	// direction choice after the window, gate close after the guarantee time
	always_comb begin
		rc    = 3'($countones(rv1));
		fc    = 3'($countones(fv1));
		up_ok = rc >= MIN_W;
		dn_ok = fc >= MIN_W;
		sel   = (up_ok && dn_ok) ? (spread(rv1, rt1) <= spread(fv1, ft1)) : up_ok;
		gate_open_d     = gate_open_q || found;
		gate_rising_d   = gd;
		chosen_valid_d  = opening ? 1'b0 : chosen_valid_q;
		chosen_rising_d = chosen_rising_q;
		if (gate_open_d && (dt > cfg.window_ticks)) begin
			if (up_ok || dn_ok) begin
				gate_rising_d   = sel;
				chosen_rising_d = sel;
				chosen_valid_d  = 1'b1;
			end
			if (dt > cfg.guarantee_ticks) begin
				gate_open_d = 1'b0;
			end
		end
	end

	// result from the updated state
	always_comb begin
		if (cfg.continuous_mode) begin
			ready  = up_ok || dn_ok;
			use_up = rc > fc;
		end else begin
			use_up = chosen_valid_d ? chosen_rising_d : 1'b1;
			ready  = chosen_valid_d && (chosen_rising_d ? &rv1 : &fv1);
		end
		for (int i = 0; i < NCH; i++) begin
			if (use_up) begin
				tout[i] = rv1[i] ? rt1[i] : NO_TIME;
			end else begin
				tout[i] = fv1[i] ? ft1[i] : NO_TIME;
			end
		end
		res.ready_res  = ready;
		res.use_rising = use_up;
		res.time_ch0   = tout[0];
		res.time_ch1   = tout[1];
		res.time_ch2   = tout[2];
		res.time_ch3   = tout[3];
	end

	// gate and choice state; a mode write closes the gate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_open_q     <= 1'b0;
			gate_rising_q   <= 1'b0;
			gate_start_q    <= '0;
			chosen_valid_q  <= 1'b0;
			chosen_rising_q <= 1'b0;
			rise_valid_q    <= '0;
			fall_valid_q    <= '0;
		end else if (mode_wr) begin
			gate_open_q    <= 1'b0;
			gate_rising_q  <= 1'b0;
			chosen_valid_q <= 1'b0;
		end else if (take) begin
			gate_open_q     <= gate_open_d;
			gate_rising_q   <= gate_rising_d;
			gate_start_q    <= start;
			chosen_valid_q  <= chosen_valid_d;
			chosen_rising_q <= chosen_rising_d;
			rise_valid_q    <= rv1;
			fall_valid_q    <= fv1;
		end
	end

	// recorded times, qualified by the valid bits
	always_ff @(posedge clk) begin
		if (take && !mode_wr) begin
			for (int i = 0; i < NCH; i++) begin
				rise_time_q[i] <= rt1[i];
				fall_time_q[i] <= ft1[i];
			end
		end
	end

	assign status.gate_open   = gate_open_q;
	assign status.gate_rising = gate_rising_q;
	assign status.rise_valid  = rise_valid_q;
	assign status.fall_valid  = fall_valid_q;

endmodule

`default_nettype wire

// ===== hdl/four_mic_crossing_time_capture.sv =====
// Top level of the four microphone crossing time capture block.
// Depends on fmct_pkg, fmct_front, fmct_fifo, fmct_back and assert_macros.svh.
//
// Usage:
//   Input channel: drive item and raise push; the item is taken at an edge
//   with push high and full low. Result channel: while empty is low the
//   oldest result sits on result; it is taken at an edge with pop high.
//   Config: cfg_we with cfg_index/cfg_data writes one register; write only
//   while the block is idle. Writing the mode register closes the gate and
//   drops the current direction choice.
// Timing:
//   One item per cycle sustained while the result queue is not full. A result
//   shows on the result port once the back end takes its item from the middle
//   queue and writes the result queue; it can be popped at the next edge
//   (front classifies into a two-entry queue, the back end updates the gate
//   state). The back end's state update per item sets this rate.
// Reset: clears the queues, the gate state, the records and the registers to
//   their defaults; previous samples start at mid scale.
// Stall: when pop stays low the result queue fills, then the middle queue,
//   then full rises; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module four_mic_crossing_time_capture
	import fmct_pkg::*;
#(
	parameter int SAMPLE_BITS = 12,
	parameter int MIN_HITS    = 3,
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire in_item_t              item,
	input  wire logic                  pop,
	output logic                       empty,
	output out_item_t                  result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t         cfg_q;
	class_item_t  cls_in;
	class_item_t  cls_out;
	out_item_t    res;
	gate_status_t gst;
	logic         accept;
	logic         mid_full;
	logic         mid_empty;
	logic         res_full;
	logic         take;
	logic         mode_wr;
	logic         other_dir_clear;

	assign full    = mid_full;
	assign accept  = push && !mid_full;
	assign mode_wr = cfg_we && (cfg_index == CFG_MODE);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.continuous_mode <= 1'b0;
			cfg_q.trigger_level   <= TRIG_RESET;
			cfg_q.hysteresis      <= HYST_RESET;
			cfg_q.window_ticks    <= WINDOW_RESET;
			cfg_q.guarantee_ticks <= GUAR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE:      cfg_q.continuous_mode <= cfg_data[0];
				CFG_TRIGGER:   cfg_q.trigger_level   <= cfg_data[SMP_W-1:0];
				CFG_HYST:      cfg_q.hysteresis      <= cfg_data[10:0];
				CFG_WINDOW:    cfg_q.window_ticks    <= cfg_data[TIME_W-1:0];
				CFG_GUARANTEE: cfg_q.guarantee_ticks <= cfg_data[TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	fmct_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.accept (accept),
		.cfg    (cfg_q),
		.cls    (cls_in)
	);

	// classified items between front and back
	fmct_fifo #(
		.WIDTH($bits(class_item_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (cls_in),
		.full    (mid_full),
		.rd_en   (take),
		.rd_data (cls_out),
		.empty   (mid_empty)
	);

	fmct_back #(
		.MIN_HITS(MIN_HITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.mode_wr   (mode_wr),
		.cls       (cls_out),
		.cls_valid (!mid_empty),
		.res_full  (res_full),
		.take      (take),
		.res       (res),
		.status    (gst)
	);

	// finished results waiting for the receiver
	fmct_fifo #(
		.WIDTH($bits(out_item_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (take),
		.wr_data (res),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);

	// records of the direction opposite to the gate are empty
	assign other_dir_clear = gst.gate_rising ? (gst.fall_valid == '0) : (gst.rise_valid == '0);

	// checks
	`ASSERT_NEXT(a_mode_closes_gate, clk, arst_n, mode_wr, !gst.gate_open)
	`ASSERT_NEXT(a_gate_opens_on_item, clk, arst_n, !gst.gate_open && !take, !gst.gate_open)
	`ASSERT_IMPLIES(a_open_clears_other, clk, arst_n, $rose(gst.gate_open), other_dir_clear)

endmodule

`default_nettype wire
